[rtl/ihex_pkg.sv]
// ----------------------------------------------------------------------------
// ihex_pkg: shared types and constants of the Intel HEX record parser
// Holds the parser state, result record, character codes and digit decoding.
// ----------------------------------------------------------------------------
package ihex_pkg;

	// Width of the running data offset counter.
	localparam int OFFSET_BITS = 24;

	localparam logic [7:0] CHAR_COLON  = 8'd58;
	localparam logic [7:0] CHAR_ZERO   = 8'd48;
	localparam logic [7:0] CHAR_NINE   = 8'd57;
	localparam logic [7:0] CHAR_UPPER_A = 8'd65;
	localparam logic [7:0] CHAR_UPPER_F = 8'd70;
	localparam logic [7:0] LETTER_BIAS = 8'd55;

	localparam logic [7:0] TYPE_DATA = 8'h00;
	localparam logic [7:0] TYPE_EOF  = 8'h01;

	typedef enum logic [2:0] {
		PH_HUNT = 3'd0,
		PH_LEN  = 3'd1,
		PH_ADDR = 3'd2,
		PH_TYPE = 3'd3,
		PH_DATA = 3'd4,
		PH_CSUM = 3'd5
	} phase_t;

	typedef enum logic [1:0] {
		KIND_DATA = 2'd0,
		KIND_EOF  = 2'd1,
		KIND_BAD  = 2'd2
	} kind_t;

	typedef struct packed {
		phase_t                 phase;
		logic [1:0]             digit_count;
		logic [7:0]             record_length;
		logic [7:0]             record_type;
		logic [3:0]             high_nibble;
		logic [7:0]             bytes_left;
		logic [OFFSET_BITS-1:0] output_count;
		logic                   finished;
	} parse_state_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  data_byte;
		logic [23:0] data_offset;
	} result_t;

	localparam parse_state_t STATE_RESET = '{
		phase:         PH_HUNT,
		digit_count:   2'd0,
		record_length: 8'd0,
		record_type:   8'd0,
		high_nibble:   4'd0,
		bytes_left:    8'd0,
		output_count:  '0,
		finished:      1'b0
	};

	// Returns {invalid, value}; only '0'-'9' and 'A'-'F' are hex digits.
	function automatic logic [4:0] hex_digit(input logic [7:0] c);
		logic [7:0] diff;
		if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
			diff = c - CHAR_ZERO;
			return {1'b0, diff[3:0]};
		end else if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_F) begin
			diff = c - LETTER_BIAS;
			return {1'b0, diff[3:0]};
		end
		return 5'b10000;
	endfunction

endpackage

[rtl/intel_hex_record_parser.sv]
// ----------------------------------------------------------------------------
// intel_hex_record_parser: Intel HEX text stream to data bytes
// Decodes records one character per beat and emits data bytes with offsets.
// ----------------------------------------------------------------------------
// Usage:
//   The char channel (char_valid, char_stall, char_in, new_file) takes one
//   ASCII character per beat. new_file clears the parser and the offset
//   counter before that character is handled.
//   The rec channel (rec_valid, rec_stall, kind, data_byte, data_offset)
//   gives at most one result per character: a data byte of a type 00 record
//   with its running offset, an end-of-file marker, or a bad-digit flag.
//   After end-of-file all characters are swallowed until new_file.
// Throughput:
//   A result is registered into the output buffer when its character is taken.
//   One character is taken every cycle while char_stall is low; the record
//   state update is a single register stage, so the rate is one character per clock.
// Stall:
//   A two-entry output buffer (output register plus skid register) lets a
//   character be taken while a result waits. char_stall rises only when
//   both entries are full, and drops the cycle after the receiver takes one.
// Reset:
//   arst_n clears the parser to hunting for ':', the offset to zero and
//   empties the output buffer.
// ----------------------------------------------------------------------------
module intel_hex_record_parser import ihex_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        char_valid,
	output logic        char_stall,
	input  logic [7:0]  char_in,
	input  logic        new_file,
	output logic        rec_valid,
	input  logic        rec_stall,
	output logic [1:0]  kind,
	output logic [7:0]  data_byte,
	output logic [23:0] data_offset
);

	parse_state_t state_q;
	parse_state_t cur;
	parse_state_t nxt;
	result_t      res;
	logic         res_valid;
	logic         accept;
	logic [4:0]   digit;
	logic [3:0]   nib;
	logic [7:0]   pair;
	logic [7:0]   left_dec;
	logic [1:0]   csum_cnt;

	result_t out_q;
	logic    out_valid_q;
	result_t skid_q;
	logic    skid_valid_q;

	assign char_stall = skid_valid_q;
	assign accept     = char_valid && !skid_valid_q;

	assign digit    = hex_digit(char_in);
	assign nib      = digit[3:0];
	assign pair     = {cur.high_nibble, nib};
	assign left_dec = cur.bytes_left - 8'd1;
	assign csum_cnt = cur.digit_count + 2'd1;

	always_comb begin
		cur       = new_file ? STATE_RESET : state_q;
		nxt       = cur;
		res       = '{kind: KIND_DATA, data_byte: 8'd0, data_offset: 24'd0};
		res_valid = 1'b0;
		if (!cur.finished) begin
			unique case (cur.phase)
				PH_CSUM: begin
					// Checksum characters are taken whatever they are.
					if (csum_cnt >= 2'd2) begin
						nxt.digit_count = 2'd0;
						nxt.phase       = PH_HUNT;
					end else begin
						nxt.digit_count = csum_cnt;
					end
				end
				PH_LEN, PH_ADDR, PH_TYPE, PH_DATA: begin
					if (digit[4]) begin
						nxt.phase       = PH_HUNT;
						nxt.digit_count = 2'd0;
						res.kind        = KIND_BAD;
						res_valid       = 1'b1;
					end else if (cur.phase == PH_ADDR) begin
						if (cur.digit_count == 2'd3) begin
							nxt.digit_count = 2'd0;
							nxt.phase       = PH_TYPE;
						end else begin
							nxt.digit_count = cur.digit_count + 2'd1;
						end
					end else if (cur.digit_count == 2'd0) begin
						nxt.high_nibble = nib;
						nxt.digit_count = 2'd1;
					end else begin
						nxt.digit_count = 2'd0;
						if (cur.phase == PH_LEN) begin
							nxt.record_length = pair;
							nxt.phase         = PH_ADDR;
						end else if (cur.phase == PH_TYPE) begin
							nxt.record_type = pair;
							nxt.bytes_left  = cur.record_length;
							if (pair == TYPE_EOF) begin
								nxt.finished = 1'b1;
								nxt.phase    = PH_HUNT;
								res.kind     = KIND_EOF;
								res_valid    = 1'b1;
							end else begin
								nxt.phase = (cur.record_length != 8'd0) ? PH_DATA : PH_CSUM;
							end
						end else begin
							nxt.bytes_left = left_dec;
							if (left_dec == 8'd0) begin
								nxt.phase = PH_CSUM;
							end
							if (cur.record_type == TYPE_DATA) begin
								nxt.output_count = cur.output_count + OFFSET_BITS'(1);
								res.data_byte    = pair;
								res.data_offset  = 24'(cur.output_count);
								res_valid        = 1'b1;
							end
						end
					end
				end
				default: begin
					if (char_in == CHAR_COLON) begin
						nxt.phase         = PH_LEN;
						nxt.digit_count   = 2'd0;
						nxt.record_length = 8'd0;
						nxt.record_type   = 8'd0;
						nxt.bytes_left    = 8'd0;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= STATE_RESET;
		end else if (accept) begin
			state_q <= nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || !rec_stall) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= accept && res_valid;
			end
		end else if (accept && res_valid) begin
			skid_valid_q <= 1'b1;
		end
	end

	// Payload registers of the output buffer carry no reset.
	always_ff @(posedge clk) begin
		if (!out_valid_q || !rec_stall) begin
			out_q <= skid_valid_q ? skid_q : res;
		end else if (accept && res_valid) begin
			skid_q <= res;
		end
	end

	assign rec_valid   = out_valid_q;
	assign kind        = out_q.kind;
	assign data_byte   = out_q.data_byte;
	assign data_offset = out_q.data_offset;

endmodule

[dv/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench of the Intel HEX record parser
// Sends a short scripted character stream and then randomized records, some
// of them corrupted or cut short, with random gaps and stalls on both
// channels. Every result beat is compared with an expectation from a behavioral
// decoder that runs in step with the accepted characters, or from a script row.
// ----------------------------------------------------------------------------
module tb_top;
	import ihex_pkg::*;

	localparam int HOLD_CYCLES = 80;
	localparam int SCRIPT_LEN  = 28;

	typedef struct packed {
		logic [7:0] ch;
		logic       nf;
		logic       typed;
		logic       hit;
		result_t    want;
	} step_row_t;

	localparam result_t NO_RESULT = '{KIND_DATA, 8'h00, 24'h000000};

	// Rows with typed set carry their expectation; the rest use the decoder.
	localparam step_row_t SCRIPT [SCRIPT_LEN] = '{
		'{8'h00,      1'b1, 1'b1, 1'b0, NO_RESULT},
		'{CHAR_COLON, 1'b0, 1'b0, 1'b0, NO_RESULT},
		'{"0",        1'b0, 1'b0, 1'b0, NO_RESULT},
		'{"1",        1'b0, 1'b0, 1'b0, NO_RESULT},
		'{"F",        1'b0, 1'b0, 1'b0, NO_RESULT},
		'{"0",        1'b0, 1'b0, 1'b0, NO_RESULT},
		'{"9",        1'b0, 1'b0, 1'b0, NO_RESULT},
		'{"A",        1'b0, 1'b0, 1'b0, NO_RESULT},
		'{"0",        1'b0, 1'b0, 1'b0, NO_RESULT},
		'{"0",        1'b0, 1'b0, 1'b0, NO_RESULT},
		'{"F",        1'b0, 1'b0, 1'b0, NO_RESULT},
		'{"F",        1'b0, 1'b1, 1'b1, '{KIND_DATA, 8'hFF, 24'h000000}},
		'{CHAR_COLON, 1'b0, 1'b0, 1'b0, NO_RESULT},
		'{8'hFF,      1'b0, 1'b0, 1'b0, NO_RESULT},
		'{CHAR_COLON, 1'b0, 1'b0, 1'b0, NO_RESULT},
		'{"a",        1'b0, 1'b1, 1'b1, '{KIND_BAD, 8'h00, 24'h000000}},
		'{CHAR_COLON, 1'b0, 1'b0, 1'b0, NO_RESULT},
		'{CHAR_COLON, 1'b0, 1'b1, 1'b1, '{KIND_BAD, 8'h00, 24'h000000}},
		'{CHAR_COLON, 1'b0, 1'b0, 1'b0, NO_RESULT},
		'{"0",        1'b0, 1'b0, 1'b0, NO_RESULT},
		'{"0",        1'b0, 1'b0, 1'b0, NO_RESULT},
		'{"0",        1'b0, 1'b0, 1'b0, NO_RESULT},
		'{"0",        1'b0, 1'b0, 1'b0, NO_RESULT},
		'{"0",        1'b0, 1'b0, 1'b0, NO_RESULT},
		'{"0",        1'b0, 1'b0, 1'b0, NO_RESULT},
		'{"0",        1'b0, 1'b0, 1'b0, NO_RESULT},
		'{"1",        1'b0, 1'b1, 1'b1, '{KIND_EOF, 8'h00, 24'h000000}},
		'{CHAR_COLON, 1'b0, 1'b1, 1'b0, NO_RESULT}
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        char_valid = 1'b0;
	logic        char_stall;
	logic [7:0]  char_in = 8'h00;
	logic        new_file = 1'b0;
	logic        rec_valid;
	logic        rec_stall = 1'b0;
	logic [1:0]  kind;
	logic [7:0]  data_byte;
	logic [23:0] data_offset;

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	bit hold_request = 1'b0;
	int useful_items = 0;
	int mismatches = 0;

	result_t     expected_results [$];
	logic [7:0]  record_text [$];

	// Decoder state.
	phase_t                 parse_phase;
	logic [1:0]             field_pos;
	logic [7:0]             rec_len_q;
	logic [7:0]             rec_type_q;
	logic [3:0]             upper_nib;
	logic [7:0]             remaining;
	logic [OFFSET_BITS-1:0] byte_offset;
	logic                   eof_seen;

	intel_hex_record_parser u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.char_valid  (char_valid),
		.char_stall  (char_stall),
		.char_in     (char_in),
		.new_file    (new_file),
		.rec_valid   (rec_valid),
		.rec_stall   (rec_stall),
		.kind        (kind),
		.data_byte   (data_byte),
		.data_offset (data_offset)
	);

	always #6 clk = ~clk;

	function automatic void clear_parser();
		parse_phase = PH_HUNT;
		field_pos = 2'd0;
		rec_len_q = 8'd0;
		rec_type_q = 8'd0;
		upper_nib = 4'd0;
		remaining = 8'd0;
		byte_offset = '0;
		eof_seen = 1'b0;
	endfunction

	// Bit 4 set means the character is not an uppercase hex digit.
	function automatic logic [4:0] digit_of(input logic [7:0] c);
		if (c >= CHAR_ZERO && c <= CHAR_NINE)
			return {1'b0, c[3:0]};
		if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_F)
			return {1'b0, c[3:0] + 4'd9};
		return 5'h10;
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] n);
		return (n < 4'd10) ? CHAR_ZERO + {4'd0, n} : CHAR_UPPER_A + {4'd0, n} - 8'd10;
	endfunction

	function automatic void push_hex(input logic [7:0] b);
		record_text.push_back(hex_char(b[7:4]));
		record_text.push_back(hex_char(b[3:0]));
	endfunction

	// Advances the decoder by one character; returns 1 when a result is due.
	function automatic bit decode_char(input logic [7:0] c, input logic nf,
			output result_t res);
		logic [4:0] dig;
		logic [7:0] pair;
		res = NO_RESULT;
		if (nf)
			clear_parser();
		if (eof_seen)
			return 1'b0;
		if (parse_phase == PH_CSUM) begin
			field_pos = field_pos + 2'd1;
			if (field_pos >= 2'd2) begin
				field_pos = 2'd0;
				parse_phase = PH_HUNT;
			end
			return 1'b0;
		end
		if (parse_phase == PH_HUNT) begin
			if (c == CHAR_COLON) begin
				parse_phase = PH_LEN;
				field_pos = 2'd0;
				rec_len_q = 8'd0;
				rec_type_q = 8'd0;
				remaining = 8'd0;
			end
			return 1'b0;
		end
		dig = digit_of(c);
		if (dig[4]) begin
			parse_phase = PH_HUNT;
			field_pos = 2'd0;
			res.kind = KIND_BAD;
			return 1'b1;
		end
		if (parse_phase == PH_ADDR) begin
			if (field_pos == 2'd3) begin
				field_pos = 2'd0;
				parse_phase = PH_TYPE;
			end else begin
				field_pos = field_pos + 2'd1;
			end
			return 1'b0;
		end
		if (field_pos == 2'd0) begin
			upper_nib = dig[3:0];
			field_pos = 2'd1;
			return 1'b0;
		end
		field_pos = 2'd0;
		pair = {upper_nib, dig[3:0]};
		case (parse_phase)
			PH_LEN: begin
				rec_len_q = pair;
				parse_phase = PH_ADDR;
				return 1'b0;
			end
			PH_TYPE: begin
				rec_type_q = pair;
				remaining = rec_len_q;
				if (pair == TYPE_EOF) begin
					eof_seen = 1'b1;
					parse_phase = PH_HUNT;
					res.kind = KIND_EOF;
					return 1'b1;
				end
				parse_phase = (rec_len_q != 8'd0) ? PH_DATA : PH_CSUM;
				return 1'b0;
			end
			default: begin
				remaining = remaining - 8'd1;
				if (remaining == 8'd0)
					parse_phase = PH_CSUM;
				if (rec_type_q == TYPE_DATA) begin
					res.data_byte = pair;
					res.data_offset = 24'(byte_offset);
					byte_offset = byte_offset + 1'b1;
					return 1'b1;
				end
				return 1'b0;
			end
		endcase
	endfunction

	task automatic offer_char(input logic [7:0] c, input logic nf, input bit typed,
			input bit typed_hit, input result_t typed_res);
		result_t res;
		bit hit;
		if ($urandom_range(99) < send_idle_pct) begin
			char_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		char_valid <= 1'b1;
		char_in <= c;
		new_file <= nf;
		do @(posedge clk); while (char_stall);
		if (nf || (!eof_seen && (parse_phase != PH_HUNT || c == CHAR_COLON)))
			useful_items++;
		hit = decode_char(c, nf, res);
		if (typed) begin
			hit = typed_hit;
			res = typed_res;
		end
		if (hit)
			expected_results.push_back(res);
	endtask

	// One record with random content, now and then corrupted or cut short.
	task automatic send_record();
		logic [7:0] rec_len;
		logic [7:0] rec_type;
		logic [7:0] c;
		logic [4:0] dig;
		int colon_at;
		int cut;
		int n;
		bit restart;
		record_text.delete();
		restart = eof_seen || ($urandom_range(49) == 0);
		if (eof_seen) begin
			repeat ($urandom_range(3))
				record_text.push_back(8'($urandom_range(255)));
		end else if ($urandom_range(3) == 0) begin
			record_text.push_back(8'h0D);
			record_text.push_back(8'h0A);
		end else if ($urandom_range(3) == 0) begin
			record_text.push_back(8'($urandom_range(255)));
		end
		colon_at = record_text.size();
		record_text.push_back(CHAR_COLON);
		if ($urandom_range(499) == 0)
			rec_len = 8'hFF;
		else if ($urandom_range(19) == 0)
			rec_len = 8'($urandom_range(32, 7));
		else
			rec_len = 8'($urandom_range(6));
		n = $urandom_range(99);
		if (n < 75)
			rec_type = TYPE_DATA;
		else if (n < 79)
			rec_type = TYPE_EOF;
		else if (n < 95)
			rec_type = 8'($urandom_range(5, 2));
		else
			rec_type = 8'($urandom_range(255));
		push_hex(rec_len);
		push_hex(8'($urandom_range(255)));
		push_hex(8'($urandom_range(255)));
		push_hex(rec_type);
		repeat (rec_len)
			push_hex(8'($urandom_range(255)));
		// The checksum is not checked, so it may be any two characters.
		if ($urandom_range(9) == 0) begin
			record_text.push_back(8'($urandom_range(255)));
			record_text.push_back(8'($urandom_range(255)));
		end else begin
			push_hex(8'($urandom_range(255)));
		end
		if ($urandom_range(9) == 0) begin
			cut = $urandom_range(record_text.size() - 3, colon_at + 1);
			case ($urandom_range(2))
				0: c = CHAR_COLON;
				1: c = 8'h61 + 8'($urandom_range(5));
				default: begin
					do begin
						c = 8'($urandom_range(255));
						dig = digit_of(c);
					end while (!dig[4]);
				end
			endcase
			record_text[cut] = c;
			if ($urandom_range(1) == 1) begin
				while (record_text.size() > cut + 1)
					void'(record_text.pop_back());
			end
		end
		for (n = 0; n < record_text.size(); n++)
			offer_char(record_text[n], (restart && n == colon_at) || ($urandom_range(299) == 0),
				1'b0, 1'b0, NO_RESULT);
	endtask

	initial begin : recv_side
		int held;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				rec_stall <= 1'b1;
				for (held = 0; held < HOLD_CYCLES; held++)
					@(posedge clk);
			end
			rec_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	always @(posedge clk) begin : rec_check
		result_t want;
		if (arst_n && rec_valid === 1'b1 && rec_stall == 1'b0) begin
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: result beat with none expected: kind %0d byte %02h offset %06h",
						$time, kind, data_byte, data_offset);
			end else begin
				want = expected_results.pop_front();
				if (kind !== want.kind || data_byte !== want.data_byte ||
						data_offset !== want.data_offset) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: expected kind %0d byte %02h offset %06h, got kind %0d byte %02h offset %06h",
							$time, want.kind, want.data_byte, want.data_offset,
							kind, data_byte, data_offset);
				end
			end
		end
	end

	initial begin
		int row;
		clear_parser();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 16;
		recv_idle_pct = 55;
		for (row = 0; row < SCRIPT_LEN; row++)
			offer_char(SCRIPT[row].ch, SCRIPT[row].nf, SCRIPT[row].typed,
				SCRIPT[row].hit, SCRIPT[row].want);
		hold_request = 1'b1;
		while (useful_items < 700)
			send_record();

		send_idle_pct = 55;
		recv_idle_pct = 16;
		while (useful_items < 1400)
			send_record();

		// No idling at all, with a long hold-off so the input side backs up.
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_request = 1'b1;
		while (useful_items < 2030)
			send_record();
		char_valid <= 1'b0;

		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatches == 0 && expected_results.size() == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("tb_top NOT OK");
		$finish;
	end

endmodule

[intel_hex_record_parser.f]
rtl/ihex_pkg.sv
rtl/intel_hex_record_parser.sv
dv/tb_top.sv
